// ===== rtl/vrp_pkg.sv =====
// vrp_pkg: types, constants and reset values shared by the packetizer files
// no dependencies
package vrp_pkg;

  localparam int unsigned DEF_MAX_FRAME_BYTES = 65536;
  localparam int unsigned DEF_QUEUE_DEPTH     = 4;

  localparam int unsigned MAX_CHUNK_W  = 11;
  localparam int unsigned FRAME_LEN_W  = 17;
  localparam int unsigned APB_ADDR_W   = 3;
  localparam int unsigned APB_DATA_W   = 32;

  localparam logic [MAX_CHUNK_W-1:0] MAX_CHUNK_RESET = 11'd1199;
  localparam logic [7:0]             RTP_VERSION_BYTE = 8'h80;
  localparam int unsigned            RTP_HEADER_LEN   = 12;

  localparam logic [3:0] POS_DESC = 4'(RTP_HEADER_LEN);
  localparam logic [3:0] POS_DATA = 4'(RTP_HEADER_LEN + 1);

  // register index taken from paddr[2]
  localparam logic REG_MAX_CHUNK = 1'b0;

  typedef enum logic [1:0] {
    JOB_DATA,
    JOB_OPEN,
    JOB_DESC
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  data;
    logic        end_flag;
    logic        marker;
    logic [15:0] seq;
    logic [6:0]  pkind;
    logic [31:0] mtime;
    logic [31:0] ssrc;
    logic [7:0]  desc;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } job_req_t;

endpackage

// ===== rtl/vrp_if.sv =====
// vrp_if: valid/ready channel interfaces for frame input and packet output
// depends on nothing
interface vrp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        frame_start;
  logic [16:0] frame_bytes;
  logic [6:0]  payload_kind;
  logic [31:0] media_time;
  logic [31:0] source_id;

  modport source (output valid, data_byte, frame_start, frame_bytes, payload_kind,
                  media_time, source_id, input ready);
  modport sink (input valid, data_byte, frame_start, frame_bytes, payload_kind,
                media_time, source_id, output ready);
endinterface

interface vrp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       packet_end;
  logic       run_last;

  modport source (output valid, out_byte, packet_end, run_last, input ready);
  modport sink (input valid, out_byte, packet_end, run_last, output ready);
endinterface

// ===== rtl/vrp_front.sv =====
// vrp_front: accepts frame words, keeps frame state, classifies each word that yields a job into one
// depends on vrp_pkg and vrp_if
module vrp_front
  import vrp_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
  input  logic                   clk,
  input  logic                   rst,
  vrp_in_if.sink                 frame,
  input  logic [MAX_CHUNK_W-1:0] max_chunk,
  input  logic                   queue_full,
  output job_req_t               req
);

  localparam int unsigned REM_W = $clog2(MAX_FRAME_BYTES);
  localparam int unsigned LEN_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned FB_W  = (LEN_W > FRAME_LEN_W) ? LEN_W : FRAME_LEN_W;
  localparam int unsigned CMP_W = (REM_W > MAX_CHUNK_W) ? REM_W : MAX_CHUNK_W;

  logic [15:0]            seq, seq_next;
  logic [7:0]             saved, saved_next;
  logic [REM_W-1:0]       remaining, remaining_next;
  logic [MAX_CHUNK_W-1:0] fill, fill_next;
  logic                   first, first_next;
  logic [6:0]             pkind, pkind_next;
  logic [31:0]            mtime, mtime_next;
  logic [31:0]            ssrc, ssrc_next;

  logic                   accept;
  logic [FB_W-1:0]        fb_ext;
  logic [LEN_W-1:0]       len;
  logic [REM_W-1:0]       rem_start;
  logic [MAX_CHUNK_W-1:0] lim;
  logic [MAX_CHUNK_W-1:0] fill_inc;
  logic [REM_W-1:0]       rem_dec;
  logic                   chunk_end;

  assign frame.ready = !queue_full;
  assign accept      = frame.valid && frame.ready;

  always_comb begin
    fb_ext = FB_W'(frame.frame_bytes);
    if (fb_ext == '0) begin
      len = LEN_W'(1);
    end else if (fb_ext > FB_W'(MAX_FRAME_BYTES)) begin
      len = LEN_W'(MAX_FRAME_BYTES);
    end else begin
      len = LEN_W'(fb_ext);
    end
    rem_start = REM_W'(len - LEN_W'(1));
    lim       = (max_chunk == '0) ? MAX_CHUNK_W'(1) : max_chunk;
    fill_inc  = fill + MAX_CHUNK_W'(1);
    rem_dec   = remaining - REM_W'(1);
    chunk_end = (rem_dec == '0) || (fill_inc >= lim);
  end

  always_comb begin
    seq_next       = seq;
    saved_next     = saved;
    remaining_next = remaining;
    fill_next      = fill;
    first_next     = first;
    pkind_next     = pkind;
    mtime_next     = mtime;
    ssrc_next      = ssrc;

    req.push         = 1'b0;
    req.job.kind     = JOB_DATA;
    req.job.data     = frame.data_byte;
    req.job.end_flag = chunk_end;
    req.job.marker   = CMP_W'(remaining) <= CMP_W'(lim);
    req.job.seq      = seq + 16'd1;
    req.job.pkind    = pkind;
    req.job.mtime    = mtime;
    req.job.ssrc     = ssrc;
    req.job.desc     = first ? saved : 8'h00;

    if (accept) begin
      if (frame.frame_start) begin
        saved_next     = frame.data_byte;
        pkind_next     = frame.payload_kind;
        mtime_next     = frame.media_time;
        ssrc_next      = frame.source_id;
        remaining_next = rem_start;
        fill_next      = '0;
        first_next     = 1'b1;
        if (rem_start == '0) begin
          // descriptor-only frame
          req.push         = 1'b1;
          req.job.kind     = JOB_DESC;
          req.job.marker   = 1'b1;
          req.job.pkind    = frame.payload_kind;
          req.job.mtime    = frame.media_time;
          req.job.ssrc     = frame.source_id;
          req.job.desc     = frame.data_byte;
          seq_next         = seq + 16'd1;
          first_next       = 1'b0;
        end
      end else if (remaining != '0) begin
        req.push       = 1'b1;
        remaining_next = rem_dec;
        if (fill == '0) begin
          req.job.kind = JOB_OPEN;
          seq_next     = seq + 16'd1;
        end
        if (chunk_end) begin
          fill_next  = '0;
          first_next = 1'b0;
        end else begin
          fill_next = fill_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq       <= '0;
      saved     <= '0;
      remaining <= '0;
      fill      <= '0;
      first     <= 1'b1;
      pkind     <= '0;
      mtime     <= '0;
      ssrc      <= '0;
    end else begin
      seq       <= seq_next;
      saved     <= saved_next;
      remaining <= remaining_next;
      fill      <= fill_next;
      first     <= first_next;
      pkind     <= pkind_next;
      mtime     <= mtime_next;
      ssrc      <= ssrc_next;
    end
  end

endmodule

// ===== rtl/vrp_queue.sv =====
// vrp_queue: short job queue between front and back, flip-flop storage
// depends on vrp_pkg
module vrp_queue
  import vrp_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  job_req_t req,
  input  logic     pop,
  output logic     full,
  output logic     head_valid,
  output job_t     head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rptr];

  always_ff @(posedge clk) begin
    if (req.push) begin
      slots[wptr] <= req.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (req.push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (req.push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !req.push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(req.push && full))
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && !head_valid))
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ===== rtl/vrp_back.sv =====
// vrp_back: expands queued jobs into header, descriptor and data words
// depends on vrp_pkg and vrp_if
module vrp_back
  import vrp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     head_valid,
  input  job_t     head,
  output logic     pop,
  vrp_out_if.source packet
);

  logic [3:0] pos;
  logic [3:0] eff_pos;
  logic [7:0] byte_sel;
  logic       last;
  logic       pend;
  logic       load;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_end;
  logic       out_last;

  always_comb begin
    eff_pos = (head.kind == JOB_DATA) ? POS_DATA : pos;
    unique case (eff_pos)
      4'd0:    byte_sel = RTP_VERSION_BYTE;
      4'd1:    byte_sel = {head.marker, head.pkind};
      4'd2:    byte_sel = head.seq[15:8];
      4'd3:    byte_sel = head.seq[7:0];
      4'd4:    byte_sel = head.mtime[31:24];
      4'd5:    byte_sel = head.mtime[23:16];
      4'd6:    byte_sel = head.mtime[15:8];
      4'd7:    byte_sel = head.mtime[7:0];
      4'd8:    byte_sel = head.ssrc[31:24];
      4'd9:    byte_sel = head.ssrc[23:16];
      4'd10:   byte_sel = head.ssrc[15:8];
      4'd11:   byte_sel = head.ssrc[7:0];
      4'd12:   byte_sel = head.desc;
      default: byte_sel = head.data;
    endcase
    last = (eff_pos == POS_DATA) || (head.kind == JOB_DESC && eff_pos == POS_DESC);
    pend = (eff_pos == POS_DATA && head.end_flag) ||
           (head.kind == JOB_DESC && eff_pos == POS_DESC);
    load = head_valid && (!out_valid || packet.ready);
    pop  = load && last;
  end

  assign packet.valid      = out_valid;
  assign packet.out_byte   = out_byte;
  assign packet.packet_end = out_end;
  assign packet.run_last   = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        pos       <= last ? 4'd0 : pos + 4'd1;
      end else if (packet.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= byte_sel;
      out_end  <= pend;
      out_last <= last;
    end
  end

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= POS_DATA)
    else $error("word position out of range");
  a_mid_job_head: assert property (@(posedge clk) disable iff (rst) pos != 4'd0 |-> head_valid)
    else $error("job left the queue before its last word");
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
                                   packet.valid && !packet.ready |=>
                                   packet.valid && $stable(packet.out_byte))
    else $error("stalled output word changed");
`endif

endmodule

// ===== rtl/vp8_rtp_packetizer.sv =====
// vp8_rtp_packetizer: top level, configuration registers and part wiring
// depends on vrp_pkg, vrp_if, vrp_front, vrp_queue and vrp_back
//
// usage
//   frame: one frame byte per word; the descriptor word carries frame_start,
//     frame_bytes, payload_kind, media_time and source_id
//   packet: the rtp stream, one byte per word, packet_end on the last byte
//     of a packet, run_last on the last word caused by one frame word
//   apb: max_chunk at address 0, to be written only while the block is idle; the block has no check for this
// throughput: one frame word a cycle while the queue has room; the back end
//   sends one output word a cycle while the receiver is ready, so a packet-opening
//   word becomes 14 output words, a descriptor-only frame 13, any other data word 1
// path: a taken frame word is written into the job queue, and the back end then
//   loads its output word from the queue head into the output register
// frame.ready drops only when the job queue (QUEUE_DEPTH entries) is full
// reset: sequence number 0, no frame in progress, max_chunk 1199; no clearing
//   pass, the block takes words in the first cycle after reset
// a stalled receiver holds the output register; the queue keeps filling
//   until it is full
module vp8_rtp_packetizer
  import vrp_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES,
  parameter int unsigned QUEUE_DEPTH     = DEF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  vrp_in_if.sink                frame,
  vrp_out_if.source             packet,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [MAX_CHUNK_W-1:0] max_chunk;
  job_req_t               req;
  logic                   queue_full;
  logic                   head_valid;
  job_t                   head;
  logic                   pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_CHUNK) ?
                  APB_DATA_W'(max_chunk) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chunk <= MAX_CHUNK_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_CHUNK) begin
      max_chunk <= pwdata[MAX_CHUNK_W-1:0];
    end
  end

  vrp_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .frame      (frame),
    .max_chunk  (max_chunk),
    .queue_full (queue_full),
    .req        (req)
  );

  vrp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  vrp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .packet     (packet)
  );

endmodule
